### rtl/twf_pkg.sv
// Shared types, widths and constants for the triangle wavefolder.
// Used by twf_cell, twf_blend and triangle_wavefolder_top; no dependencies.
package twf_pkg;

    localparam int SAMPLE_WIDTH = 24;
    localparam int FRAC_BITS    = 20;

    // fold amount, Q1.16, 65536 = 1.0
    localparam int AMT_W = 17;
    localparam int K_W   = 16;
    localparam int FOLD_K = 47186;   // 0.72 in Q0.16
    localparam logic [AMT_W-1:0] AMT_ONE   = AMT_W'(65536);
    localparam logic [AMT_W-1:0] AMT_RESET = AMT_W'(32768);

    // internal widths
    localparam int XW   = FRAC_BITS + 4;   // clamped sample, signed
    localparam int MW   = FRAC_BITS + 3;   // magnitude / residue, unsigned
    localparam int TW   = FRAC_BITS + 1;   // threshold, unsigned
    localparam int PERW = FRAC_BITS + 4;   // period multiples up to 8T
    localparam int EW   = (SAMPLE_WIDTH > XW) ? SAMPLE_WIDTH : XW;
    localparam int DW   = MW + 2;
    localparam int PROD_W = XW + AMT_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int PA_W   = AMT_W + K_W;
    localparam int TSH    = 32 - FRAC_BITS;

    localparam longint ONE_L  = longint'(1) << FRAC_BITS;
    localparam longint LIM    = longint'(1) << (FRAC_BITS + 2);
    localparam longint SMAX   = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
    localparam longint OUT_HI = (LIM < SMAX) ? LIM : SMAX;
    localparam longint OUT_LO = (LIM <= SMAX) ? -LIM : -(SMAX + 1);

    localparam logic signed [EW-1:0] LIM_E    = EW'(LIM);
    localparam logic signed [XW-1:0] OUT_HI_X = XW'(OUT_HI);
    localparam logic signed [XW-1:0] OUT_LO_X = XW'(OUT_LO);
    localparam logic [TW-1:0]        THR_ONE  = TW'(ONE_L);
    localparam logic [PA_W-1:0]      T_RND    = PA_W'(longint'(1) << (TSH - 1));
    localparam logic [TW-1:0]        THR_RESET = TW'(ONE_L
        - ((longint'(32768) * FOLD_K + (longint'(1) << (TSH - 1))) >>> TSH));
    localparam logic signed [SUM_W-1:0] BLEND_RND = SUM_W'(32768);

    // one sample moving down the fold chain
    typedef struct packed {
        logic signed [XW-1:0] x;       // clamped input
        logic                 neg;
        logic                 bypass;  // |x| <= T, no folding
        logic [MW-1:0]        r;       // |x| when bypassed, else residue
    } pipe_t;

    // T = ONE - round(a * 0.72 * ONE)
    function automatic logic [TW-1:0] thr_of(input logic [AMT_W-1:0] a);
        logic [PA_W-1:0] prod;
        logic [PA_W-1:0] sh;
        prod = a * K_W'(FOLD_K);
        sh   = (prod + T_RND) >> TSH;
        return THR_ONE - TW'(sh);
    endfunction

endpackage

### rtl/twf_cell.sv
// One compare-subtract cell of the modulo chain: takes off one period multiple.
// Depends on twf_pkg.
module twf_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  twf_pkg::pipe_t             in_data,
    input  logic [twf_pkg::PERW-1:0]   period,
    output logic                       out_valid,
    input  logic                       out_ready,
    output twf_pkg::pipe_t             out_data
);

    logic           valid_reg;
    logic           valid_next;
    twf_pkg::pipe_t data_reg;
    twf_pkg::pipe_t data_next;
    logic [twf_pkg::PERW-1:0] r_ext;
    logic           take;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        r_ext     = twf_pkg::PERW'(in_data.r);
        data_next = in_data;
        if (!in_data.bypass && (r_ext >= period))
        begin
            data_next.r = twf_pkg::MW'(r_ext - period);
        end
        if (take)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // residue left by this cell is below its own period
    a_residue_below_period: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !data_reg.bypass) |-> (twf_pkg::PERW'(data_reg.r) < period))
        else $error("twf_cell: residue not reduced below period");

endmodule

### rtl/twf_blend.sv
// Fold reconstruction, dry/wet products and rounded, saturated sum (3 stages).
// Depends on twf_pkg.
module twf_blend (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  twf_pkg::pipe_t                    in_data,
    input  logic [twf_pkg::TW-1:0]            thr,
    input  logic [twf_pkg::AMT_W-1:0]         amt,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [twf_pkg::SAMPLE_WIDTH-1:0] sample_out
);

    logic v1_reg, v1_next, v2_reg, v2_next, v3_reg, v3_next;
    logic rdy1, rdy2, rdy3;
    logic take1, take2, take3;

    logic signed [twf_pkg::XW-1:0]     x1_reg;
    logic signed [twf_pkg::XW-1:0]     f1_reg;
    logic signed [twf_pkg::PROD_W-1:0] px2_reg;
    logic signed [twf_pkg::PROD_W-1:0] pf2_reg;
    logic signed [twf_pkg::SAMPLE_WIDTH-1:0] out_reg;

    logic signed [twf_pkg::DW-1:0]  d;
    logic signed [twf_pkg::DW-1:0]  dabs;
    logic [twf_pkg::DW-1:0]         fm;
    logic [twf_pkg::MW-1:0]         fmag;
    logic signed [twf_pkg::XW-1:0]  fs;
    logic signed [twf_pkg::XW-1:0]  f1_next;
    logic signed [twf_pkg::AMT_W:0] dry;
    logic signed [twf_pkg::AMT_W:0] wet;
    logic signed [twf_pkg::PROD_W-1:0] px2_next;
    logic signed [twf_pkg::PROD_W-1:0] pf2_next;
    logic signed [twf_pkg::SUM_W-1:0]  s;
    logic signed [twf_pkg::SUM_W-1:0]  y;
    logic signed [twf_pkg::SUM_W-1:0]  yc;
    logic signed [twf_pkg::XW-1:0]     yx;
    logic signed [twf_pkg::SAMPLE_WIDTH-1:0] out_next;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;
    assign take1    = in_valid && rdy1;
    assign take2    = v1_reg && rdy2;
    assign take3    = v2_reg && rdy3;

    // stage 1: T - |r - T| (r itself when bypassed), sign restored
    always_comb
    begin
        d    = $signed(twf_pkg::DW'(in_data.r)) - $signed(twf_pkg::DW'(thr));
        dabs = (d < 0) ? -d : d;
        fm   = twf_pkg::DW'(thr) - twf_pkg::DW'(dabs);
        fmag = in_data.bypass ? in_data.r : twf_pkg::MW'(fm);
        fs   = $signed(twf_pkg::XW'(fmag));
        f1_next = in_data.neg ? -fs : fs;
    end

    // stage 2: x*(1-a) and f*a
    always_comb
    begin
        dry      = $signed({1'b0, twf_pkg::AMT_ONE - amt});
        wet      = $signed({1'b0, amt});
        px2_next = x1_reg * dry;
        pf2_next = f1_reg * wet;
    end

    // stage 3: round half up, floor by 2^16, saturate
    always_comb
    begin
        s = twf_pkg::SUM_W'(px2_reg) + twf_pkg::SUM_W'(pf2_reg) + twf_pkg::BLEND_RND;
        y = s >>> 16;
        if (y > twf_pkg::SUM_W'(twf_pkg::OUT_HI_X))
            yc = twf_pkg::SUM_W'(twf_pkg::OUT_HI_X);
        else if (y < twf_pkg::SUM_W'(twf_pkg::OUT_LO_X))
            yc = twf_pkg::SUM_W'(twf_pkg::OUT_LO_X);
        else
            yc = y;
        yx       = twf_pkg::XW'(yc);
        out_next = twf_pkg::SAMPLE_WIDTH'(yx);
    end

    always_comb
    begin
        v1_next = take1 ? 1'b1 : (rdy2 ? 1'b0 : v1_reg);
        v2_next = take2 ? 1'b1 : (rdy3 ? 1'b0 : v2_reg);
        v3_next = take3 ? 1'b1 : (out_ready ? 1'b0 : v3_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take1)
        begin
            x1_reg <= in_data.x;
            f1_reg <= f1_next;
        end
        if (take2)
        begin
            px2_reg <= px2_next;
            pf2_reg <= pf2_next;
        end
        if (take3)
            out_reg <= out_next;
    end

    assign out_valid  = v3_reg;
    assign sample_out = out_reg;

    // folded value never leaves the band [-T, T]
    a_fold_in_band: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> ((f1_reg <= $signed(twf_pkg::XW'(thr)))
                 && (f1_reg >= -$signed(twf_pkg::XW'(thr)))))
        else $error("twf_blend: folded value outside threshold band");

endmodule

### rtl/triangle_wavefolder_top.sv
// Pipeline: an accepted request passes through 7 registered stages
// (front, 3 modulo cells, fold, multiply, sum/saturate), each with valid/ready.
// Throughput: one request per cycle while out_ready holds; each stage refills as soon as its successor takes.
// Reset: all stage valids cleared, fold_amount returns to 0.5 and its threshold is
// preloaded, so requests are taken from the first cycle after reset.
// Top level of the triangle wavefolder; depends on twf_pkg, twf_cell, twf_blend.
module triangle_wavefolder_top (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    fold_amount_we,
    input  logic [twf_pkg::AMT_W-1:0]               fold_amount,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [twf_pkg::SAMPLE_WIDTH-1:0] sample_in,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [twf_pkg::SAMPLE_WIDTH-1:0] sample_out
);

    localparam int NCELL = 3;

    logic [twf_pkg::AMT_W-1:0] amt_reg;
    logic [twf_pkg::AMT_W-1:0] amt_next;
    logic [twf_pkg::TW-1:0]    thr_reg;
    logic [twf_pkg::TW-1:0]    thr_next;

    logic           chain_valid [NCELL+1];
    logic           chain_ready [NCELL+1];
    twf_pkg::pipe_t chain_data  [NCELL+1];

    logic           fr_valid_reg;
    logic           fr_valid_next;
    twf_pkg::pipe_t fr_data_reg;
    twf_pkg::pipe_t fr_data_next;
    logic           take;

    logic signed [twf_pkg::EW-1:0] ext;
    logic signed [twf_pkg::EW-1:0] clamped;
    logic signed [twf_pkg::XW-1:0] xc;
    logic [twf_pkg::XW-1:0]        magx;
    logic [twf_pkg::MW-1:0]        m;
    logic                          bypass;

    // config: clamp above 1.0 and precompute threshold on write
    always_comb
    begin
        amt_next = (fold_amount > twf_pkg::AMT_ONE) ? twf_pkg::AMT_ONE : fold_amount;
        thr_next = twf_pkg::thr_of(amt_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amt_reg <= twf_pkg::AMT_RESET;
            thr_reg <= twf_pkg::THR_RESET;
        end
        else if (fold_amount_we)
        begin
            amt_reg <= amt_next;
            thr_reg <= thr_next;
        end
    end

    // front stage: clamp, magnitude, bypass test, first subtraction of T unless bypassed
    always_comb
    begin
        ext = twf_pkg::EW'(sample_in);
        if (ext > twf_pkg::LIM_E)
            clamped = twf_pkg::LIM_E;
        else if (ext < -twf_pkg::LIM_E)
            clamped = -twf_pkg::LIM_E;
        else
            clamped = ext;
        xc     = twf_pkg::XW'(clamped);
        magx   = xc[twf_pkg::XW-1] ? twf_pkg::XW'(-xc) : twf_pkg::XW'(xc);
        m      = magx[twf_pkg::MW-1:0];
        bypass = (m <= twf_pkg::MW'(thr_reg));
        fr_data_next.x      = xc;
        fr_data_next.neg    = xc[twf_pkg::XW-1];
        fr_data_next.bypass = bypass;
        fr_data_next.r      = bypass ? m : (m - twf_pkg::MW'(thr_reg));
    end

    assign in_ready = !fr_valid_reg || chain_ready[0];
    assign take     = in_valid && in_ready;

    always_comb
    begin
        if (take)
            fr_valid_next = 1'b1;
        else if (chain_ready[0])
            fr_valid_next = 1'b0;
        else
            fr_valid_next = fr_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fr_valid_reg <= 1'b0;
        else
            fr_valid_reg <= fr_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            fr_data_reg <= fr_data_next;
    end

    assign chain_valid[0] = fr_valid_reg;
    assign chain_data[0]  = fr_data_reg;

    // modulo by 2T: cells subtract 8T, 4T, 2T in turn
    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        twf_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .period    (twf_pkg::PERW'(thr_reg) << (NCELL - i)),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    twf_blend u_blend (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (chain_valid[NCELL]),
        .in_ready   (chain_ready[NCELL]),
        .in_data    (chain_data[NCELL]),
        .thr        (thr_reg),
        .amt        (amt_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out)
    );

    a_out_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((twf_pkg::XW'(sample_out) <= twf_pkg::OUT_HI_X)
                    && (twf_pkg::XW'(sample_out) >= twf_pkg::OUT_LO_X)))
        else $error("triangle_wavefolder_top: result outside saturation range");

    a_thr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (thr_reg <= twf_pkg::THR_ONE) && (thr_reg > twf_pkg::THR_ONE >> 2))
        else $error("triangle_wavefolder_top: threshold outside (0.25, 1.0]");

endmodule
